>>> rtl/vnts_pkg.sv
package vnts_pkg;

	// table geometry and coordinate width
	localparam int MAX_SEEDS  = 64;
	localparam int COORD_BITS = 10;
	localparam int IDX_W      = $clog2(MAX_SEEDS);
	localparam int N_W        = $clog2(MAX_SEEDS + 1);

	// fixed field widths
	localparam int CMD_W  = 1;
	localparam int SLOT_W = 6;
	localparam int POS_W  = 10;
	localparam int CFG_W  = 7;
	localparam int DIST_W = 21;

	// squared distance before saturation
	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

	localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
	localparam logic [CFG_W-1:0]  ACTIVE_RESET = CFG_W'(20);
	localparam int                MIN_SEEDS    = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SEED  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_PIXEL = 1'b1;

	// tag riding along with each seed read through the distance pipe
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [IDX_W-1:0] idx;
	} dist_tag_t;

endpackage

>>> rtl/voronoi_nearest_two_seed_search_core.sv
// Pixel query: the core scans seeds 0..n-1, where n is active_seeds clamped to
// 2..64, through the single read port of the seed table, one seed read per cycle;
// the result is loaded into the output register and a new item is taken once idle.
// Out-of-region pixels skip the scan; seed writes are taken while idle.
// Reset (arst_n low, asynchronous): idle, no result pending, running max 0,
// active_seeds 20. Seed table contents are undefined until written.
module voronoi_nearest_two_seed_search_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [vnts_pkg::CMD_W-1:0]    command,
	input  logic [vnts_pkg::SLOT_W-1:0]   seed_slot,
	input  logic [vnts_pkg::POS_W-1:0]    pos_x,
	input  logic [vnts_pkg::POS_W-1:0]    pos_y,
	input  logic                          in_region,
	input  logic                          frame_start,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [vnts_pkg::IDX_W-1:0]    nearest_seed,
	output logic [vnts_pkg::DIST_W-1:0]   nearest_dist,
	output logic [vnts_pkg::DIST_W-1:0]   edge_value,
	output logic [vnts_pkg::DIST_W-1:0]   frame_max,
	output logic                          pixel_valid,
	// config channel: active_seeds
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vnts_pkg::CFG_W-1:0]    cfg_data
);
	import vnts_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                state_q;
	logic                  in_beat;
	logic                  seed_beat;
	logic                  pix_beat;
	logic                  fin_fire;

	logic [CFG_W-1:0]      active_q;
	logic [N_W-1:0]        n_clamped;
	logic [N_W-1:0]        n_q;
	logic [N_W-1:0]        rd_cnt_q;
	logic                  rd_en;

	logic [COORD_BITS-1:0] px_q;
	logic [COORD_BITS-1:0] py_q;
	logic                  region_q;

	logic [IDX_W-1:0]      best_q;
	logic [DIST_W-1:0]     d1_q;
	logic [DIST_W-1:0]     d2_q;
	logic [DIST_W-1:0]     run_max_q;
	logic [DIST_W-1:0]     edge_w;
	logic [DIST_W-1:0]     new_max;

	logic [SQ_W-1:0]       ram_rdata;
	dist_tag_t             tag_s1;
	dist_tag_t             tag_s3;
	logic [DIST_W-1:0]     dist_s3;
	logic                  is_first;
	logic                  is_second;

	logic                  out_valid_q;
	logic [IDX_W-1:0]      out_seed_q;
	logic [DIST_W-1:0]     out_d1_q;
	logic [DIST_W-1:0]     out_edge_q;
	logic [DIST_W-1:0]     out_max_q;
	logic                  out_region_q;

	// ---------------- handshakes ----------------
	// Input taken only when idle; the output register decouples the result side,
	// so a waiting result beat does not hold off the next item.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign seed_beat = in_beat && (command == CMD_SEED);
	assign pix_beat  = in_beat && (command == CMD_PIXEL);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// clamp the search count to 2..MAX_SEEDS
	always_comb begin
		if (active_q < CFG_W'(MIN_SEEDS)) begin
			n_clamped = N_W'(MIN_SEEDS);
		end else if (int'(active_q) > MAX_SEEDS) begin
			n_clamped = N_W'(MAX_SEEDS);
		end else begin
			n_clamped = N_W'(active_q);
		end
	end

	// ---------------- seed table ----------------
	// {x, y} per entry. Writes happen only while idle and reads only while
	// scanning, so the two ports never touch the same entry in one cycle.
	assign rd_en = (state_q == ST_SCAN) && (rd_cnt_q < n_q);

	vnts_ram #(
		.WIDTH (SQ_W),
		.DEPTH (MAX_SEEDS)
	) u_seed_ram (
		.clk   (clk),
		.we    (seed_beat && (int'(seed_slot) < MAX_SEEDS)),
		.waddr (IDX_W'(seed_slot)),
		.wdata ({pos_x[COORD_BITS-1:0], pos_y[COORD_BITS-1:0]}),
		.re    (rd_en),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// tag lines up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= rd_en;
			tag_s1.last  <= rd_en && ((rd_cnt_q + N_W'(1)) == n_q);
			tag_s1.idx   <= rd_cnt_q[IDX_W-1:0];
		end
	end

	vnts_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.seed_x_s1 (ram_rdata[SQ_W-1:COORD_BITS]),
		.seed_y_s1 (ram_rdata[COORD_BITS-1:0]),
		.px        (px_q),
		.py        (py_q),
		.tag_s3    (tag_s3),
		.dist_s3   (dist_s3)
	);

	// ---------------- control ----------------
	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rd_cnt_q <= '0;
					if (pix_beat) begin
						state_q <= in_region ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + N_W'(1);
					end
					if (tag_s3.valid && tag_s3.last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// pixel context, held for the whole scan
	always_ff @(posedge clk) begin
		if (pix_beat) begin
			px_q     <= pos_x[COORD_BITS-1:0];
			py_q     <= pos_y[COORD_BITS-1:0];
			region_q <= in_region;
			n_q      <= n_clamped;
		end
	end

	// ---------------- top-two tracker ----------------
	// Strict less-than keeps the lowest index on ties for the nearest.
	// Entry 0 only seeds d1; entry 1 always lands in d1 or d2.
	assign is_first  = (tag_s3.idx == '0);
	assign is_second = (tag_s3.idx == IDX_W'(1));

	always_ff @(posedge clk) begin
		if (pix_beat) begin
			best_q <= '0;
			d1_q   <= in_region ? DIST_MAX : '0;
			d2_q   <= in_region ? DIST_MAX : '0;
		end else if (state_q == ST_SCAN && tag_s3.valid) begin
			if (is_first || (dist_s3 < d1_q)) begin
				if (!is_first) begin
					d2_q <= d1_q;
				end
				d1_q   <= dist_s3;
				best_q <= tag_s3.idx;
			end else if (is_second || (dist_s3 < d2_q)) begin
				d2_q <= dist_s3;
			end
		end
	end

	// out-of-region: d1 = d2 = 0, so edge is 0 and the max is left alone
	assign edge_w  = d2_q - d1_q;
	assign new_max = (edge_w > run_max_q) ? edge_w : run_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_max_q <= '0;
		end else if (pix_beat && frame_start) begin
			run_max_q <= '0;
		end else if (fin_fire) begin
			run_max_q <= new_max;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			out_seed_q   <= best_q;
			out_d1_q     <= d1_q;
			out_edge_q   <= edge_w;
			out_max_q    <= new_max;
			out_region_q <= region_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign nearest_seed = out_seed_q;
	assign nearest_dist = out_d1_q;
	assign edge_value   = out_edge_q;
	assign frame_max    = out_max_q;
	assign pixel_valid  = out_region_q;

	// ---------------- checks ----------------
	// the tracker must leave nearest no farther than second-nearest
	a_top_two_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (d1_q <= d2_q))
		else $error("nearest distance above second-nearest");

	// distance pipe must drain before the scan ends
	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s3.valid |-> (state_q == ST_SCAN))
		else $error("distance beat outside scan");

	// a reported edge value never exceeds the reported frame maximum
	a_edge_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (edge_value <= frame_max))
		else $error("edge value above frame maximum");

	// a scan never reads past the clamped seed count
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_cnt_q <= n_q))
		else $error("seed read beyond active count");

endmodule

>>> rtl/vnts_ram.sv
module vnts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/vnts_dist.sv
module vnts_dist (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vnts_pkg::dist_tag_t                tag_s1,
	input  logic [vnts_pkg::COORD_BITS-1:0]    seed_x_s1,
	input  logic [vnts_pkg::COORD_BITS-1:0]    seed_y_s1,
	input  logic [vnts_pkg::COORD_BITS-1:0]    px,
	input  logic [vnts_pkg::COORD_BITS-1:0]    py,
	output vnts_pkg::dist_tag_t                tag_s3,
	output logic [vnts_pkg::DIST_W-1:0]        dist_s3
);
	import vnts_pkg::*;

	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic [SQ_W-1:0]       sqx_s2;
	logic [SQ_W-1:0]       sqy_s2;
	dist_tag_t             tag_s2;
	dist_tag_t             tag_s3_q;
	logic [DIST_W-1:0]     dist_s3_q;
	logic [SUM_W-1:0]      sum;
	logic [CMP_W-1:0]      sum_wide;
	logic [DIST_W-1:0]     dist_sat;

	assign dx = (seed_x_s1 > px) ? (seed_x_s1 - px) : (px - seed_x_s1);
	assign dy = (seed_y_s1 > py) ? (seed_y_s1 - py) : (py - seed_y_s1);

	// s2: squares
	always_ff @(posedge clk) begin
		sqx_s2 <= SQ_W'(dx) * SQ_W'(dx);
		sqy_s2 <= SQ_W'(dy) * SQ_W'(dy);
	end

	// s3: sum, saturate
	assign sum      = SUM_W'(sqx_s2) + SUM_W'(sqy_s2);
	assign sum_wide = CMP_W'(sum);
	assign dist_sat = (sum_wide > CMP_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum_wide);

	always_ff @(posedge clk) begin
		dist_s3_q <= dist_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2   <= '0;
			tag_s3_q <= '0;
		end else begin
			tag_s2   <= tag_s1;
			tag_s3_q <= tag_s2;
		end
	end

	assign tag_s3  = tag_s3_q;
	assign dist_s3 = dist_s3_q;

endmodule

>>> dv/tb_voronoi_nearest_two_seed_search_core.sv
module tb_voronoi_nearest_two_seed_search_core;

	import vnts_pkg::*;

	// generous bound: ~750 beats, each at worst a full scan plus both sides' gaps,
	// idle waits between phases and the long result hold, taken several times over
	localparam int LIMIT_CYCLES = 400000;
	// a seed write raises no result; give the core its longest scan before cfg writes
	localparam int SETTLE_CYCLES = 80;

	// one input beat as the core sees it
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic              region;
		logic              fstart;
	} search_req_t;

	// one result beat
	typedef struct packed {
		logic [IDX_W-1:0]  seed;
		logic [DIST_W-1:0] near_d;
		logic [DIST_W-1:0] edge_val;
		logic [DIST_W-1:0] fmax;
		logic              in_reg;
	} pixel_res_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [CMD_W-1:0]  command     = CMD_SEED;
	logic [SLOT_W-1:0] seed_slot   = '0;
	logic [POS_W-1:0]  pos_x       = '0;
	logic [POS_W-1:0]  pos_y       = '0;
	logic              in_region   = 1'b0;
	logic              frame_start = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [IDX_W-1:0]  nearest_seed;
	logic [DIST_W-1:0] nearest_dist;
	logic [DIST_W-1:0] edge_value;
	logic [DIST_W-1:0] frame_max;
	logic              pixel_valid;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data    = '0;

	// predictor state: seed table, running max and search count, kept in step
	// with the core by updating at every accepted beat
	logic [POS_W-1:0]  seed_xs [MAX_SEEDS];
	logic [POS_W-1:0]  seed_ys [MAX_SEEDS];
	logic [DIST_W-1:0] peak_edge   = '0;
	logic [CFG_W-1:0]  seed_count  = ACTIVE_RESET;

	pixel_res_t        expected_pixels [$];
	int                err_count   = 0;
	int                cycles      = 0;
	bit                no_idle     = 1'b0;   // both sides run back to back
	int                hold_len    = 0;      // one-shot long stall of the result side

	voronoi_nearest_two_seed_search_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.seed_slot    (seed_slot),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.in_region    (in_region),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.nearest_seed (nearest_seed),
		.nearest_dist (nearest_dist),
		.edge_value   (edge_value),
		.frame_max    (frame_max),
		.pixel_valid  (pixel_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run guard: a hang anywhere ends the run as a failure
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_field(input string fname, input logic [DIST_W-1:0] got,
			input logic [DIST_W-1:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0d expected %0d", fname, got, want));
	endtask

	// Worley F2-F1 over the first n seeds. Applies a beat to the predictor
	// state; returns 1 when the beat yields a result.
	function automatic bit search_nearest_two(input search_req_t req, output pixel_res_t res);
		int unsigned n, i, d, d1, d2, dx, dy, sx, sy, px, py;
		logic [IDX_W-1:0] best;
		res = '0;
		if (req.cmd == CMD_SEED) begin
			// region and frame bits mean nothing on a seed write
			seed_xs[req.slot] = req.x;
			seed_ys[req.slot] = req.y;
			return 1'b0;
		end
		if (req.fstart)
			peak_edge = '0;
		best = '0;
		d1   = 0;
		d2   = 0;
		if (req.region) begin
			n = seed_count;
			if (n < MIN_SEEDS)
				n = MIN_SEEDS;
			if (n > MAX_SEEDS)
				n = MAX_SEEDS;
			d1 = DIST_MAX;
			d2 = DIST_MAX;
			px = req.x;
			py = req.y;
			for (i = 0; i < n; i++) begin
				sx = seed_xs[i];
				sy = seed_ys[i];
				dx = (sx > px) ? sx - px : px - sx;
				dy = (sy > py) ? sy - py : py - sy;
				d  = dx * dx + dy * dy;
				if (d > DIST_MAX)
					d = DIST_MAX;
				// strict compare keeps the lowest index on a tie
				if (i == 0 || d < d1) begin
					if (i != 0)
						d2 = d1;
					d1   = d;
					best = IDX_W'(i);
				end else if (i == 1 || d < d2) begin
					d2 = d;
				end
			end
			if (DIST_W'(d2 - d1) > peak_edge)
				peak_edge = DIST_W'(d2 - d1);
		end
		res.seed     = best;
		res.near_d   = DIST_W'(d1);
		res.edge_val = DIST_W'(d2 - d1);
		res.fmax     = peak_edge;
		res.in_reg   = req.region;
		return 1'b1;
	endfunction

	// One input beat. The gap is drawn per beat; valid is only lowered when
	// a gap follows, so back-to-back beats never see a low/high pair in one step.
	task automatic send_item(input search_req_t req);
		int         gap;
		pixel_res_t res;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= req.cmd;
		seed_slot   <= req.slot;
		pos_x       <= req.x;
		pos_y       <= req.y;
		in_region   <= req.region;
		frame_start <= req.fstart;
		do @(posedge clk); while (in_stall);
		if (search_nearest_two(req, res))
			expected_pixels = {expected_pixels, res};
	endtask

	task automatic write_seed(input int slot, input int x, input int y,
			input bit region = 1'b0, input bit fstart = 1'b0);
		send_item('{CMD_SEED, SLOT_W'(slot), POS_W'(x), POS_W'(y), region, fstart});
	endtask

	task automatic query_pixel(input int x, input int y, input bit region, input bit fstart);
		send_item('{CMD_PIXEL, SLOT_W'(0), POS_W'(x), POS_W'(y), region, fstart});
	endtask

	// sender pause: drain every pending result, then let a trailing seed write finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the core idle
	task automatic write_seed_count(input int value);
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		seed_count  = CFG_W'(value);
	endtask

	function automatic int rand_coord();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return (1 << POS_W) - 1;
		return $urandom_range(0, (1 << POS_W) - 1);
	endfunction

	// result side: a random stall before each beat, plus a one-shot long hold
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			k = no_idle ? 0 : $urandom_range(0, 5);
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall) && hold_len == 0);
		end
	end

	// result checker: pre-edge sampling of the handshake, oldest expectation first
	always @(posedge clk) begin
		pixel_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				report_error($sformatf("result beat with nothing expected, seed %0d dist %0d",
					nearest_seed, nearest_dist));
			end else begin
				want = expected_pixels.pop_front();
				check_field("nearest_seed", nearest_seed, want.seed);
				check_field("nearest_dist", nearest_dist, want.near_d);
				check_field("edge_value", edge_value, want.edge_val);
				check_field("frame_max", frame_max, want.fmax);
				check_field("pixel_valid", pixel_valid, want.in_reg);
			end
		end
	end

	// Every slot gets written first so no search ever reads a blank entry.
	// The first pixel keeps frame_start low: its max checks the cleared
	// running max, and the count used checks the reset value of 20.
	task automatic test_reset_state();
		for (int s = 0; s < MAX_SEEDS; s++)
			write_seed(s, rand_coord(), rand_coord(), $urandom_range(0, 1), $urandom_range(0, 1));
		query_pixel(rand_coord(), rand_coord(), 1'b1, 1'b0);
		query_pixel(rand_coord(), rand_coord(), 1'b1, 1'b0);
		wait_idle();
	endtask

	// opposite corners: largest distance, largest edge, equidistant corners
	task automatic test_corner_coords();
		write_seed_count(MIN_SEEDS);
		write_seed(0, 0, 0);
		write_seed(1, 1023, 1023);
		query_pixel(0, 0, 1'b1, 1'b1);
		query_pixel(1023, 1023, 1'b1, 1'b0);
		query_pixel(1023, 0, 1'b1, 1'b0);
		query_pixel(0, 1023, 1'b1, 1'b0);
		query_pixel(512, 511, 1'b1, 1'b0);
		wait_idle();
	endtask

	// seed writes with frame_start high, region low or high, must not touch the max
	task automatic test_ignored_fields();
		write_seed(63, 1023, 0, 1'b0, 1'b1);
		write_seed(62, 0, 1023, 1'b1, 1'b1);
		query_pixel(100, 900, 1'b1, 1'b0);
		wait_idle();
	endtask

	// outside pixels: zeros, max held or cleared by frame_start
	task automatic test_outside_region();
		query_pixel(1023, 1023, 1'b0, 1'b0);
		query_pixel(0, 0, 1'b0, 1'b1);
		query_pixel(300, 300, 1'b1, 1'b0);
		wait_idle();
	endtask

	// counts below 2 act as 2, above 64 act as 64
	task automatic test_seed_count_clamp();
		int counts [5] = '{0, 1, 65, 127, MAX_SEEDS};
		foreach (counts[c]) begin
			write_seed_count(counts[c]);
			query_pixel(rand_coord(), rand_coord(), 1'b1, 1'b0);
			wait_idle();
		end
	endtask

	// duplicate seeds: lowest index wins, F2 equal to F1 gives edge 0
	task automatic test_equal_distances();
		write_seed_count(4);
		write_seed(0, 7, 7);
		write_seed(1, 7, 7);
		write_seed(2, 3, 3);
		write_seed(3, 3, 3);
		query_pixel(3, 3, 1'b1, 1'b1);
		query_pixel(7, 7, 1'b1, 1'b0);
		query_pixel(5, 5, 1'b1, 1'b0);
		wait_idle();
	endtask

	// result side held for a long stretch while pixels keep coming: the core
	// fills and must stall its input without dropping or reordering beats
	task automatic test_result_backpressure();
		write_seed_count(3);
		hold_len = 300;
		for (int i = 0; i < 12; i++)
			query_pixel(rand_coord(), rand_coord(), 1'b1, i == 0);
		wait_idle();
	endtask

	// phases of mixed traffic, each under a fresh search count; mostly small
	// counts to keep scans short, with the full table now and then
	task automatic test_random_traffic();
		int r, cnt, s;
		for (int ph = 0; ph < 12; ph++) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				cnt = $urandom_range(0, 8);
			else if (r < 9)
				cnt = $urandom_range(9, 127);
			else
				cnt = MAX_SEEDS;
			no_idle = (ph == 5);
			write_seed_count(cnt);
			for (int i = 0; i < 54; i++) begin
				r = $urandom_range(0, 99);
				if (r < 20) begin
					write_seed($urandom_range(0, MAX_SEEDS - 1), rand_coord(), rand_coord(),
						$urandom_range(0, 1), $urandom_range(0, 1));
				end else if (r < 35) begin
					// land on a stored seed to provoke zero distances and ties
					s = $urandom_range(0, 7);
					query_pixel(seed_xs[s], seed_ys[s], 1'b1, $urandom_range(0, 9) == 0);
				end else begin
					query_pixel(rand_coord(), rand_coord(), $urandom_range(0, 9) != 0,
						$urandom_range(0, 9) == 0);
				end
			end
			wait_idle();
			no_idle = 1'b0;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_corner_coords();
		test_ignored_fields();
		test_outside_region();
		test_seed_count_clamp();
		test_equal_distances();
		test_result_backpressure();
		test_random_traffic();
		// drained by the last wait_idle; a little more time for stray beats
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
